// ===== src/tsk_pkg.sv =====
// Shared types, sizes and codes of the topological sort block.
// Used by the interfaces, the sort engine and the top level; depends on nothing.
package tsk_pkg;

   localparam int MAX_NODES = 64;
   localparam int MAX_EDGES = 256;

   // Node ids are six bits wide, so no more than 64 nodes can ever be in use.
   localparam int ID_W       = 6;
   localparam int ID_REACH   = 64;
   localparam int NODE_LIMIT = (MAX_NODES < ID_REACH) ? MAX_NODES : ID_REACH;
   localparam int NODE_AW    = (NODE_LIMIT > 1) ? $clog2(NODE_LIMIT) : 1;
   localparam int NODE_CW    = $clog2(NODE_LIMIT + 1);
   localparam int CFG_W      = 7;

   localparam int EDGE_AW    = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
   localparam int EDGE_CW    = $clog2(MAX_EDGES + 1);
   localparam int DEG_W      = EDGE_CW;

   localparam logic [1:0] ACT_LOAD  = 2'd0;
   localparam logic [1:0] ACT_SORT  = 2'd1;
   localparam logic [1:0] ACT_CLEAR = 2'd2;

   typedef struct packed {
      logic [1:0]      action;
      logic [ID_W-1:0] edge_source;
      logic [ID_W-1:0] edge_target;
   } item_type;

   typedef struct packed {
      logic [ID_W-1:0] node_id;
      logic            node_valid;
      logic            cycle_found;
      logic            edges_dropped;
      logic            last;
   } result_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_CLR,
      S_CNT_RD,
      S_CNT_IDX,
      S_CNT_WR,
      S_SEED_RD,
      S_SEED_CHK,
      S_POP,
      S_POP_ID,
      S_WK_RD,
      S_WK_IDX,
      S_WK_WR,
      S_EMIT,
      S_NONE
   } sort_state_type;

endpackage

// ===== src/tsk_if.sv =====
// Valid/ready channel interfaces for the request and response sides.
// Depends on tsk_pkg for the field widths.
interface tsk_req_if;
   logic                     valid;
   logic                     ready;
   logic [1:0]               action;
   logic [tsk_pkg::ID_W-1:0] edge_source;
   logic [tsk_pkg::ID_W-1:0] edge_target;

   modport source (output valid, action, edge_source, edge_target, input ready);
   modport sink   (input valid, action, edge_source, edge_target, output ready);
endinterface

interface tsk_rsp_if;
   logic                     valid;
   logic                     ready;
   logic [tsk_pkg::ID_W-1:0] node_id;
   logic                     node_valid;
   logic                     cycle_found;
   logic                     edges_dropped;
   logic                     last;

   modport source (output valid, node_id, node_valid, cycle_found, edges_dropped, last,
                   input ready);
   modport sink   (input valid, node_id, node_valid, cycle_found, edges_dropped, last,
                   output ready);
endinterface

// ===== src/topological_sort_kahn.sv =====
// Top level of the Kahn topological sort block: channel ports, node count
// register and response register. Depends on tsk_pkg, tsk_if and tsk_engine.
//
// Usage. Every request transaction carries an action and one edge. A load
// appends the edge to a 256-entry edge store and a clear empties the store
// and clears the sticky drop flag; neither produces a response, and loads
// stream at one per cycle while no sort is running. A sort runs Kahn's
// algorithm over nodes 0 to node_count-1, clipped to at most 64 nodes, and
// returns one response transaction per ordered node in topological order,
// zero in-degree nodes seeded in ascending id order. The final response
// carries last, and cycle_found when fewer nodes came out than are in use.
// When no node can be ordered, a single response with node_valid low and
// last high is returned. A sort clears the in-degrees, counts them in a walk
// over the single-port edge store, seeds the ready queue, then walks the
// whole edge store again for every emitted node. Responses are registered on
// the way out. A stalled receiver holds the response register; the engine
// waits on it and resumes when it drains.
// Reset is synchronous and active high; it empties the edge store, clears the
// drop flag and sets node_count to zero. No memory clearing pass is needed.
module topological_sort_kahn (
   input  logic                       clock,
   input  logic                       reset,
   tsk_req_if.sink                    req_ch,
   tsk_rsp_if.source                  rsp_ch,
   input  logic                       csr_we,
   input  logic [tsk_pkg::CFG_W-1:0]  csr_wdata
);
   import tsk_pkg::*;

   // Node count register; the user must write it only while the engine is idle, the block does not enforce it.
   logic [CFG_W-1:0] node_count_ff;

   item_type   item;
   result_type res;
   logic       res_valid;
   logic       res_ready;

   // Response register that separates the engine from the receiver.
   logic       rsp_valid_ff;
   result_type rsp_data_ff;

   assign item = '{action: req_ch.action, edge_source: req_ch.edge_source,
                   edge_target: req_ch.edge_target};

   tsk_engine u_engine (
      .clock      (clock),
      .reset      (reset),
      .item       (item),
      .item_valid (req_ch.valid),
      .item_ready (req_ch.ready),
      .node_count (node_count_ff),
      .res        (res),
      .res_valid  (res_valid),
      .res_ready  (res_ready)
   );

   // The engine may hand over a new result whenever the register is empty
   // or is being emptied in this same cycle.
   assign res_ready = !rsp_valid_ff || rsp_ch.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         node_count_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_we) node_count_ff <= csr_wdata;
         if (res_valid && res_ready) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (res_valid && res_ready) rsp_data_ff <= res;
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.node_id       = rsp_data_ff.node_id;
   assign rsp_ch.node_valid    = rsp_data_ff.node_valid;
   assign rsp_ch.cycle_found   = rsp_data_ff.cycle_found;
   assign rsp_ch.edges_dropped = rsp_data_ff.edges_dropped;
   assign rsp_ch.last          = rsp_data_ff.last;

endmodule

// ===== src/tsk_engine.sv =====
// Sort engine: edge store, in-degree memory, ready queue and the sequencer
// that walks them. Depends on tsk_pkg.
module tsk_engine (
   input  logic                         clock,
   input  logic                         reset,
   input  tsk_pkg::item_type            item,
   input  logic                         item_valid,
   output logic                         item_ready,
   input  logic [tsk_pkg::CFG_W-1:0]    node_count,
   output tsk_pkg::result_type          res,
   output logic                         res_valid,
   input  logic                         res_ready
);
   import tsk_pkg::*;

   sort_state_type       state_ff, state_in;
   logic [EDGE_CW-1:0]   edge_total_ff, edge_total_in;
   logic                 overflow_ff, overflow_in;
   logic [EDGE_CW-1:0]   eidx_ff, eidx_in;
   logic [NODE_CW-1:0]   vidx_ff, vidx_in;
   logic [NODE_CW-1:0]   head_ff, head_in;
   logic [NODE_CW-1:0]   tail_ff, tail_in;
   logic [ID_W-1:0]      cur_id_ff, cur_id_in;

   logic [2*ID_W-1:0]    edge_mem [MAX_EDGES];
   logic [2*ID_W-1:0]    edge_rd_ff;
   logic                 edge_we, edge_re;
   logic [EDGE_AW-1:0]   edge_waddr, edge_raddr;

   logic [DEG_W-1:0]     deg_mem [NODE_LIMIT];
   logic [DEG_W-1:0]     deg_rd_ff;
   logic                 deg_we, deg_re;
   logic [NODE_AW-1:0]   deg_waddr, deg_raddr;
   logic [DEG_W-1:0]     deg_wdata;

   logic [ID_W-1:0]      fifo_mem [NODE_LIMIT];
   logic [ID_W-1:0]      fifo_rd_ff;
   logic                 fifo_we, fifo_re;
   logic [NODE_AW-1:0]   fifo_waddr, fifo_raddr;
   logic [ID_W-1:0]      fifo_wdata;

   logic [NODE_CW-1:0]   n_lim;
   logic [ID_W-1:0]      e_src, e_tgt;
   logic                 e_in_range;
   logic                 queue_done;

   assign n_lim = (node_count > CFG_W'(NODE_LIMIT)) ? NODE_CW'(NODE_LIMIT)
                                                    : NODE_CW'(node_count);
   assign e_src = edge_rd_ff[2*ID_W-1:ID_W];
   assign e_tgt = edge_rd_ff[ID_W-1:0];
   assign e_in_range = (CFG_W'(e_src) < CFG_W'(n_lim)) && (CFG_W'(e_tgt) < CFG_W'(n_lim));
   assign queue_done = (head_ff == tail_ff);

   always_ff @(posedge clock) begin
      if (edge_we) edge_mem[edge_waddr] <= {item.edge_source, item.edge_target};
      if (edge_re) edge_rd_ff <= edge_mem[edge_raddr];
      if (deg_we) deg_mem[deg_waddr] <= deg_wdata;
      if (deg_re) deg_rd_ff <= deg_mem[deg_raddr];
      if (fifo_we) fifo_mem[fifo_waddr] <= fifo_wdata;
      if (fifo_re) fifo_rd_ff <= fifo_mem[fifo_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         edge_total_ff <= '0;
         overflow_ff   <= 1'b0;
         eidx_ff       <= '0;
         vidx_ff       <= '0;
         head_ff       <= '0;
         tail_ff       <= '0;
      end else begin
         state_ff      <= state_in;
         edge_total_ff <= edge_total_in;
         overflow_ff   <= overflow_in;
         eidx_ff       <= eidx_in;
         vidx_ff       <= vidx_in;
         head_ff       <= head_in;
         tail_ff       <= tail_in;
      end
      cur_id_ff <= cur_id_in;
   end

   always_comb begin
      state_in      = state_ff;
      edge_total_in = edge_total_ff;
      overflow_in   = overflow_ff;
      eidx_in       = eidx_ff;
      vidx_in       = vidx_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      cur_id_in     = cur_id_ff;
      item_ready    = 1'b0;
      edge_we       = 1'b0;
      edge_re       = 1'b0;
      edge_waddr    = edge_total_ff[EDGE_AW-1:0];
      edge_raddr    = eidx_ff[EDGE_AW-1:0];
      deg_we        = 1'b0;
      deg_re        = 1'b0;
      deg_waddr     = e_tgt[NODE_AW-1:0];
      deg_raddr     = e_tgt[NODE_AW-1:0];
      deg_wdata     = deg_rd_ff + DEG_W'(1);
      fifo_we       = 1'b0;
      fifo_re       = 1'b0;
      fifo_waddr    = tail_ff[NODE_AW-1:0];
      fifo_raddr    = head_ff[NODE_AW-1:0];
      fifo_wdata    = e_tgt;
      res_valid     = 1'b0;
      res           = '{node_id: cur_id_ff, node_valid: 1'b1,
                        cycle_found: queue_done && (head_ff < n_lim),
                        edges_dropped: overflow_ff, last: queue_done};

      case (state_ff)
         S_IDLE: begin
            item_ready = 1'b1;
            if (item_valid) begin
               case (item.action)
                  ACT_LOAD: begin
                     if (edge_total_ff < EDGE_CW'(MAX_EDGES)) begin
                        edge_we       = 1'b1;
                        edge_total_in = edge_total_ff + EDGE_CW'(1);
                     end else begin
                        overflow_in = 1'b1;
                     end
                  end
                  ACT_SORT: begin
                     vidx_in  = '0;
                     head_in  = '0;
                     tail_in  = '0;
                     state_in = S_CLR;
                  end
                  ACT_CLEAR: begin
                     edge_total_in = '0;
                     overflow_in   = 1'b0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_CLR: begin
            if (vidx_ff < n_lim) begin
               deg_we    = 1'b1;
               deg_waddr = vidx_ff[NODE_AW-1:0];
               deg_wdata = '0;
               vidx_in   = vidx_ff + NODE_CW'(1);
            end else begin
               eidx_in  = '0;
               state_in = S_CNT_RD;
            end
         end
         S_CNT_RD: begin
            if (eidx_ff < edge_total_ff) begin
               edge_re  = 1'b1;
               state_in = S_CNT_IDX;
            end else begin
               vidx_in  = '0;
               state_in = S_SEED_RD;
            end
         end
         S_CNT_IDX: begin
            if (e_in_range) begin
               deg_re   = 1'b1;
               state_in = S_CNT_WR;
            end else begin
               eidx_in  = eidx_ff + EDGE_CW'(1);
               state_in = S_CNT_RD;
            end
         end
         S_CNT_WR: begin
            deg_we   = 1'b1;
            eidx_in  = eidx_ff + EDGE_CW'(1);
            state_in = S_CNT_RD;
         end
         S_SEED_RD: begin
            if (vidx_ff < n_lim) begin
               deg_re    = 1'b1;
               deg_raddr = vidx_ff[NODE_AW-1:0];
               state_in  = S_SEED_CHK;
            end else begin
               state_in = S_POP;
            end
         end
         S_SEED_CHK: begin
            if (deg_rd_ff == '0 && tail_ff < n_lim) begin
               fifo_we    = 1'b1;
               fifo_wdata = ID_W'(vidx_ff);
               tail_in    = tail_ff + NODE_CW'(1);
            end
            vidx_in  = vidx_ff + NODE_CW'(1);
            state_in = S_SEED_RD;
         end
         S_POP: begin
            if (head_ff < tail_ff) begin
               fifo_re  = 1'b1;
               head_in  = head_ff + NODE_CW'(1);
               state_in = S_POP_ID;
            end else begin
               state_in = S_NONE;
            end
         end
         S_POP_ID: begin
            cur_id_in = fifo_rd_ff;
            eidx_in   = '0;
            state_in  = S_WK_RD;
         end
         S_WK_RD: begin
            if (eidx_ff < edge_total_ff) begin
               edge_re  = 1'b1;
               state_in = S_WK_IDX;
            end else begin
               state_in = S_EMIT;
            end
         end
         S_WK_IDX: begin
            if (e_in_range && e_src == cur_id_ff) begin
               deg_re   = 1'b1;
               state_in = S_WK_WR;
            end else begin
               eidx_in  = eidx_ff + EDGE_CW'(1);
               state_in = S_WK_RD;
            end
         end
         S_WK_WR: begin
            if (deg_rd_ff != '0) begin
               deg_we    = 1'b1;
               deg_wdata = deg_rd_ff - DEG_W'(1);
               if (deg_rd_ff == DEG_W'(1) && tail_ff < n_lim) begin
                  fifo_we = 1'b1;
                  tail_in = tail_ff + NODE_CW'(1);
               end
            end
            eidx_in  = eidx_ff + EDGE_CW'(1);
            state_in = S_WK_RD;
         end
         S_EMIT: begin
            res_valid = 1'b1;
            if (res_ready) begin
               state_in = queue_done ? S_IDLE : S_POP;
            end
         end
         S_NONE: begin
            res_valid = 1'b1;
            res       = '{node_id: '0, node_valid: 1'b0, cycle_found: (n_lim != '0),
                          edges_dropped: overflow_ff, last: 1'b1};
            if (res_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   a_queue_order: assert property (@(posedge clock) disable iff (reset)
      head_ff <= tail_ff) else $error("queue head passed its tail");

   a_store_bound: assert property (@(posedge clock) disable iff (reset)
      edge_total_ff <= EDGE_CW'(MAX_EDGES)) else $error("edge count beyond store size");

   a_empty_is_last: assert property (@(posedge clock) disable iff (reset)
      res_valid && !res.node_valid |-> res.last)
      else $error("result without a node is not the final one");

   a_last_ends_run: assert property (@(posedge clock) disable iff (reset)
      res_valid && res_ready && res.last |=> state_ff == S_IDLE)
      else $error("sort run continued after its final result");

   a_emit_has_node: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_EMIT |-> head_ff != '0) else $error("node emitted before any pop");

endmodule

// ===== verif/tb_topological_sort_kahn.sv =====
// Self-checking testbench for the Kahn topological sort block.
// Depends on tsk_pkg, the tsk_req_if/tsk_rsp_if interfaces and topological_sort_kahn.
// A built-in predictor of the sort checks every response transaction field by field.
module tb_topological_sort_kahn;
   timeunit 1ns;
   timeprecision 1ps;

   import tsk_pkg::*;

   // Action code 3 has no meaning in the block; it must be swallowed silently.
   localparam logic [1:0] ACT_UNUSED = 2'd3;

   // The engine goes back to idle as soon as its last result is handed over, and
   // loads and clears produce no response, so a short pause covers anything still in flight.
   localparam int SETTLE_CYCLES = 16;
   localparam int HOLD_CYCLES   = 400;
   localparam int RANDOM_ITEMS  = 70;
   localparam int CYCLE_LIMIT   = 10_000_000;

   logic             clock;
   logic             reset;
   logic             csr_we;
   logic [CFG_W-1:0] csr_wdata;

   tsk_req_if req_ch ();
   tsk_rsp_if rsp_ch ();

   topological_sort_kahn dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   // Shadow copy of the block's architectural state, updated as transactions
   // are accepted and as the node count register is written.
   logic [CFG_W-1:0] shadow_node_count = '0;
   logic [ID_W-1:0]  shadow_src [MAX_EDGES];
   logic [ID_W-1:0]  shadow_dst [MAX_EDGES];
   int               shadow_edge_count = 0;
   logic             shadow_dropped = 1'b0;

   // Orders still owed by the block, oldest first, and the requests not yet sent.
   result_type order_expected [$];
   item_type   items_pending [$];

   int items_queued   = 0;
   int items_taken    = 0;
   int random_items   = 0;
   int sorts_taken    = 0;
   int cyclic_runs    = 0;
   int overflow_runs  = 0;
   int results_seen   = 0;
   int config_writes  = 0;
   int mismatches     = 0;
   int cycle_count    = 0;
   int send_gap       = 0;
   int recv_gap       = 0;
   bit quiet_phase    = 1'b0;
   bit pressure_go    = 1'b0;
   bit hold_rsp       = 1'b0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Every mismatch goes through here: one line, one count. Printing stops
   // after the first twenty so a broken block cannot flood the log.
   task automatic report_mismatch(input string msg);
      mismatches++;
      if (mismatches <= 20) begin
         $display("MISMATCH cycle %0d: %s", cycle_count, msg);
      end
   endtask

   task automatic check_field(input string name, input int got, input int want);
      if (got != want) begin
         report_mismatch($sformatf("%s got %0d expected %0d (response %0d)",
                                   name, got, want, results_seen));
      end
   endtask

   // Gap lengths are drawn from three ranges: short ones most often, medium ones
   // sometimes, and now and then a long pause.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return $urandom_range(1, 3);
      if (r < 95) return $urandom_range(4, 12);
      return $urandom_range(20, 80);
   endfunction

   // Predicts the full response sequence of one sort over the shadow state.
   // Zero in-degree nodes are seeded in ascending id order; each emitted node
   // then walks the whole edge list and releases targets that drop to zero.
   function automatic void predict_order();
      result_type run [MAX_NODES];
      int         degree [MAX_NODES];
      int         ready_ids [MAX_NODES];
      int         n;
      int         head;
      int         tail;
      int         emitted;
      int         id;
      int         t;
      result_type r;
      n = (shadow_node_count > NODE_LIMIT) ? NODE_LIMIT : int'(shadow_node_count);
      head = 0;
      tail = 0;
      emitted = 0;
      for (int v = 0; v < MAX_NODES; v++) degree[v] = 0;
      // Edges with either end outside the nodes in use are ignored entirely.
      for (int e = 0; e < shadow_edge_count; e++) begin
         if (shadow_src[e] < n && shadow_dst[e] < n) degree[shadow_dst[e]]++;
      end
      for (int v = 0; v < n; v++) begin
         if (degree[v] == 0) begin
            ready_ids[tail] = v;
            tail++;
         end
      end
      while (head < tail) begin
         id = ready_ids[head];
         head++;
         r = '0;
         r.node_id = id[ID_W-1:0];
         r.node_valid = 1'b1;
         r.edges_dropped = shadow_dropped;
         run[emitted] = r;
         emitted++;
         for (int e = 0; e < shadow_edge_count; e++) begin
            t = shadow_dst[e];
            if (shadow_src[e] == id && t < n && degree[t] > 0) begin
               degree[t]--;
               if (degree[t] == 0 && tail < n) begin
                  ready_ids[tail] = t;
                  tail++;
               end
            end
         end
      end
      if (shadow_dropped) overflow_runs++;
      if (emitted == 0) begin
         // Nothing could be ordered: a lone marker response closes the run.
         r = '0;
         r.cycle_found = (n > 0);
         r.edges_dropped = shadow_dropped;
         r.last = 1'b1;
         order_expected.insert(order_expected.size(), r);
         if (n > 0) cyclic_runs++;
      end else begin
         run[emitted-1].cycle_found = (emitted < n);
         run[emitted-1].last = 1'b1;
         if (emitted < n) cyclic_runs++;
         for (int k = 0; k < emitted; k++) order_expected.insert(order_expected.size(), run[k]);
      end
   endfunction

   // Applies one accepted request transaction to the shadow state.
   function automatic void apply_item(input logic [1:0] act, input logic [ID_W-1:0] src,
                                      input logic [ID_W-1:0] dst);
      case (act)
         ACT_LOAD: begin
            if (shadow_edge_count < MAX_EDGES) begin
               shadow_src[shadow_edge_count] = src;
               shadow_dst[shadow_edge_count] = dst;
               shadow_edge_count++;
            end else begin
               shadow_dropped = 1'b1;
            end
         end
         ACT_SORT: begin
            sorts_taken++;
            predict_order();
         end
         ACT_CLEAR: begin
            shadow_edge_count = 0;
            shadow_dropped = 1'b0;
         end
         default: begin
         end
      endcase
   endfunction

   // Request driver. Items leave the pending queue one at a time; each one may
   // be followed by a random gap unless the current phase runs without idling.
   // Payload and valid change only when the channel is free or just took a
   // transaction, so a stalled offer stays stable.
   always @(posedge clock) begin : request_driver
      item_type nxt;
      if (reset) begin
         req_ch.valid <= 1'b0;
         req_ch.action <= ACT_LOAD;
         req_ch.edge_source <= '0;
         req_ch.edge_target <= '0;
         send_gap <= 0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            items_taken++;
            apply_item(req_ch.action, req_ch.edge_source, req_ch.edge_target);
         end
         if (!req_ch.valid || req_ch.ready) begin
            if (send_gap > 0) begin
               send_gap <= send_gap - 1;
               req_ch.valid <= 1'b0;
            end else if (items_pending.size() > 0) begin
               nxt = items_pending[0];
               items_pending.delete(0);
               req_ch.action <= nxt.action;
               req_ch.edge_source <= nxt.edge_source;
               req_ch.edge_target <= nxt.edge_target;
               req_ch.valid <= 1'b1;
               send_gap <= (quiet_phase || $urandom_range(0, 2) != 0) ? 0 : pick_gap();
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // Response monitor. Every accepted response transaction is checked against
   // the oldest predicted one. Ready drops for random stretches, and for one
   // long stretch while the pressure hold is active.
   always @(posedge clock) begin : response_monitor
      result_type want;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         recv_gap <= 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            results_seen++;
            if (order_expected.size() == 0) begin
               report_mismatch($sformatf("response with none expected: node_id %0d last %0d",
                                         rsp_ch.node_id, rsp_ch.last));
            end else begin
               want = order_expected[0];
               order_expected.delete(0);
               check_field("node_id", rsp_ch.node_id, want.node_id);
               check_field("node_valid", rsp_ch.node_valid, want.node_valid);
               check_field("cycle_found", rsp_ch.cycle_found, want.cycle_found);
               check_field("edges_dropped", rsp_ch.edges_dropped, want.edges_dropped);
               check_field("last", rsp_ch.last, want.last);
            end
         end
         if (hold_rsp) begin
            rsp_ch.ready <= 1'b0;
         end else if (recv_gap > 0) begin
            recv_gap <= recv_gap - 1;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
            if (!quiet_phase && $urandom_range(0, 4) == 0) recv_gap <= pick_gap();
         end
      end
   end

   // The long receiver hold-off, timed here in its own process. While it lasts
   // the response register fills, the engine stops, and the request side stalls.
   initial begin : receiver_hold
      wait (pressure_go);
      @(posedge clock);
      hold_rsp <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_rsp <= 1'b0;
   end

   // Watchdog: a hung handshake or a missing response ends the run here.
   always @(posedge clock) begin : watchdog
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   task automatic queue_item(input logic [1:0] act, input int src, input int dst);
      item_type it;
      it.action = act;
      it.edge_source = src[ID_W-1:0];
      it.edge_target = dst[ID_W-1:0];
      items_pending.insert(items_pending.size(), it);
      items_queued++;
   endtask

   // Blocks until every request has been taken and every predicted response
   // has come back.
   task automatic wait_idle();
      @(posedge clock);
      while (!(items_pending.size() == 0 && items_taken == items_queued &&
               order_expected.size() == 0)) begin
         @(posedge clock);
      end
   endtask

   // The node count register is only written with the block fully idle; the
   // settle pause covers a trailing load or clear that produces no response.
   task automatic set_node_count(input int value);
      wait_idle();
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_we <= 1'b1;
      csr_wdata <= value[CFG_W-1:0];
      @(posedge clock);
      csr_we <= 1'b0;
      shadow_node_count = value[CFG_W-1:0];
      config_writes++;
   endtask

   // Node counts lean toward small graphs so that sorts stay short, with the
   // full 64 nodes, oversized values that clip to 64, and zero mixed in.
   function automatic int pick_node_count();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return $urandom_range(1, 12);
      if (r < 72) return $urandom_range(13, 63);
      if (r < 84) return NODE_LIMIT;
      if (r < 92) return $urandom_range(65, 127);
      return 0;
   endfunction

   // One random graph: usually a fresh store, mostly forward edges so the
   // graph stays acyclic and the sort gets deep, plus back edges, self edges,
   // out-of-range ends and the odd unused action or stray sort as noise.
   task automatic random_graph_run();
      int span;
      int count;
      int r;
      int s;
      int t;
      span = (shadow_node_count > NODE_LIMIT) ? NODE_LIMIT : int'(shadow_node_count);
      if ($urandom_range(0, 4) != 0) begin
         queue_item(ACT_CLEAR, $urandom_range(0, 63), $urandom_range(0, 63));
         random_items++;
      end
      count = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 12);
      for (int k = 0; k < count; k++) begin
         r = $urandom_range(0, 99);
         if (span < 2 || r >= 85) begin
            if (r >= 97) begin
               queue_item(ACT_UNUSED, $urandom_range(0, 63), $urandom_range(0, 63));
            end else if (r >= 94) begin
               queue_item(ACT_SORT, $urandom_range(0, 63), $urandom_range(0, 63));
               random_items++;
            end else begin
               queue_item(ACT_LOAD, $urandom_range(0, 63), $urandom_range(0, 63));
               random_items++;
            end
         end else begin
            if (r < 70) begin
               s = $urandom_range(0, span - 2);
               t = $urandom_range(s + 1, span - 1);
            end else if (r < 80) begin
               t = $urandom_range(0, span - 2);
               s = $urandom_range(t + 1, span - 1);
            end else begin
               s = $urandom_range(0, span - 1);
               t = s;
            end
            queue_item(ACT_LOAD, s, t);
            random_items++;
         end
      end
      queue_item(ACT_SORT, $urandom_range(0, 63), $urandom_range(0, 63));
      random_items++;
   endtask

   initial begin : stimulus
      int s;
      reset = 1'b1;
      csr_we = 1'b0;
      csr_wdata = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed part. With no nodes in use the sort can only answer with
      // the empty marker, and no cycle is flagged.
      set_node_count(0);
      queue_item(ACT_SORT, 0, 0);

      // A small acyclic graph with one edge leaving the node range at each end,
      // and an unused action that must produce nothing.
      set_node_count(4);
      queue_item(ACT_LOAD, 0, 1);
      queue_item(ACT_LOAD, 1, 2);
      queue_item(ACT_LOAD, 0, 2);
      queue_item(ACT_LOAD, 5, 1);
      queue_item(ACT_LOAD, 2, 63);
      queue_item(ACT_UNUSED, 63, 63);
      queue_item(ACT_SORT, 0, 0);
      // A self edge on node 3 leaves it forever blocked, so a cycle shows.
      queue_item(ACT_LOAD, 3, 3);
      queue_item(ACT_SORT, 63, 63);
      // An empty store orders every node in ascending id order.
      queue_item(ACT_CLEAR, 0, 0);
      queue_item(ACT_SORT, 0, 0);

      // Two nodes pointing at each other: nothing can be emitted at all.
      set_node_count(2);
      queue_item(ACT_CLEAR, 63, 63);
      queue_item(ACT_LOAD, 0, 1);
      queue_item(ACT_LOAD, 1, 0);
      queue_item(ACT_SORT, 0, 0);

      // Full node range with a cycle through the highest and lowest ids.
      set_node_count(NODE_LIMIT);
      queue_item(ACT_CLEAR, 0, 0);
      queue_item(ACT_LOAD, 63, 0);
      queue_item(ACT_LOAD, 0, 63);
      queue_item(ACT_LOAD, 62, 61);
      queue_item(ACT_SORT, 0, 0);

      // The largest register value clips to 64 nodes; a single node comes last.
      set_node_count(127);
      queue_item(ACT_SORT, 0, 0);
      set_node_count(1);
      queue_item(ACT_SORT, 0, 0);

      // Random part: graph after graph, with the node count changed between
      // some of them and some phases run with no idling on either side.
      while (random_items < RANDOM_ITEMS) begin
         if ($urandom_range(0, 3) == 0) set_node_count(pick_node_count());
         quiet_phase = ($urandom_range(0, 5) == 0);
         random_graph_run();
      end
      quiet_phase = 1'b0;

      // Back-pressure: a full 64-node sort starts while the receiver is held
      // off, and further transactions keep being offered behind it.
      set_node_count(NODE_LIMIT);
      queue_item(ACT_CLEAR, 0, 0);
      queue_item(ACT_LOAD, 10, 20);
      queue_item(ACT_LOAD, 20, 30);
      pressure_go = 1'b1;
      queue_item(ACT_SORT, 0, 0);
      for (int k = 0; k < 6; k++) queue_item(ACT_LOAD, $urandom_range(0, 31),
                                             $urandom_range(32, 63));
      queue_item(ACT_SORT, 0, 0);

      // Store overflow: fill all 256 entries with a random DAG, drop two more,
      // sort with the sticky flag set, then show that a clear resets it.
      wait_idle();
      queue_item(ACT_CLEAR, 0, 0);
      for (int k = 0; k < MAX_EDGES + 2; k++) begin
         s = $urandom_range(0, 62);
         queue_item(ACT_LOAD, s, $urandom_range(s + 1, 63));
      end
      queue_item(ACT_SORT, 0, 0);
      queue_item(ACT_CLEAR, 0, 0);
      queue_item(ACT_LOAD, 0, 1);
      queue_item(ACT_SORT, 0, 0);

      wait_idle();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (order_expected.size() != 0) begin
         report_mismatch($sformatf("%0d responses never arrived", order_expected.size()));
      end

      $display("Run covered %0d request transactions, %0d sorts and %0d checked responses.",
               items_taken, sorts_taken, results_seen);
      $display("%0d node count writes, %0d runs ending in a cycle, %0d with dropped edges.",
               config_writes, cyclic_runs, overflow_runs);
      if (mismatches == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
